// ===== design/dsfmt_linear_generator_top_assert.svh =====
// Assertion macros used by the generator's top level.
`ifndef DSFMT_LINEAR_GENERATOR_TOP_ASSERT_SVH
`define DSFMT_LINEAR_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define DSFMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define DSFMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dsfmt_lg_pkg.sv =====
package dsfmt_lg_pkg;

  localparam int WORD_COUNT  = 191;
  localparam int ADDR_W      = $clog2(WORD_COUNT);
  localparam int LANE_W      = 64;
  localparam int VALUE_W     = 52;
  localparam int SHIFT_RIGHT = 12;
  localparam int LUNG_ROT    = 32;
  localparam int OFF_W       = 8;
  localparam int SHIFT_W     = 6;
  // load count runs 0 .. 2N+2, read position 0 .. 2N
  localparam int LC_W        = $clog2(2 * WORD_COUNT + 3);
  localparam int POS_W       = $clog2(2 * WORD_COUNT + 1);
  localparam int BPTR_W      = (ADDR_W > OFF_W) ? ADDR_W : OFF_W;
  localparam int CFG_IDX_W   = 2;

  typedef logic [1:0]        op_t;
  typedef logic [LANE_W-1:0] lane_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_DRAW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PICK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;       // write accepted seed lane
    logic start;      // start request: clear counts, arm zero check
    logic pos_clear;  // draw wrap: read position back to 0
    logic scan_chk;   // fold current word into the zero check
    logic idx_step;   // advance word index
    logic guard;      // force lung low lane to 1 if everything was zero
    logic off_load;   // load offset pointer, clear word index
    logic off_sub;    // offset pointer minus word count
    logic gen_wr;     // write back one recursed word, update lung
    logic rd_lane;    // port A reads the lane at the read position
    logic emit;       // capture lane into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic off_ge;
    logic pos_end;
    logic out_free;
  } status_t;

endpackage

// ===== design/dsfmt_lg_ram.sv =====
module dsfmt_lg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== design/dsfmt_lg_ctrl.sv =====
module dsfmt_lg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dsfmt_lg_pkg::op_t     op_i,
  input  dsfmt_lg_pkg::status_t status_i,
  output dsfmt_lg_pkg::cmd_t    cmd_o
);

  import dsfmt_lg_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_RD  = 3'd1;
  localparam logic [2:0] ST_SCAN_CHK = 3'd2;
  localparam logic [2:0] ST_REDUCE   = 3'd3;
  localparam logic [2:0] ST_GEN_RD   = 3'd4;
  localparam logic [2:0] ST_GEN_WR   = 3'd5;
  localparam logic [2:0] ST_EMIT_RD  = 3'd6;
  localparam logic [2:0] ST_EMIT     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD: begin
              cmd_o.load = 1'b1;
            end
            OP_START: begin
              cmd_o.start = 1'b1;
              state_d     = ST_SCAN_RD;
            end
            OP_DRAW: begin
              if (status_i.pos_end) begin
                cmd_o.pos_clear = 1'b1;
                cmd_o.off_load  = 1'b1;
                state_d         = ST_REDUCE;
              end else begin
                state_d = ST_EMIT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.guard    = 1'b1;
          cmd_o.off_load = 1'b1;
          state_d        = ST_REDUCE;
        end else begin
          cmd_o.idx_step = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      ST_REDUCE: begin
        if (status_i.off_ge) begin
          cmd_o.off_sub = 1'b1;
        end else begin
          state_d = ST_GEN_RD;
        end
      end
      ST_GEN_RD: begin
        state_d = ST_GEN_WR;
      end
      ST_GEN_WR: begin
        cmd_o.gen_wr = 1'b1;
        state_d      = status_i.idx_last ? ST_EMIT_RD : ST_GEN_RD;
      end
      ST_EMIT_RD: begin
        cmd_o.rd_lane = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.rd_lane = 1'b1;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/dsfmt_lg_datapath.sv =====
module dsfmt_lg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [dsfmt_lg_pkg::LANE_W-1:0]     seed_word_i,
  input  logic                                cfg_we_i,
  input  logic [dsfmt_lg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dsfmt_lg_pkg::LANE_W-1:0]     cfg_wdata_i,
  input  dsfmt_lg_pkg::cmd_t                  cmd_i,
  output dsfmt_lg_pkg::status_t               status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dsfmt_lg_pkg::VALUE_W-1:0]    random_value_o
);

  import dsfmt_lg_pkg::*;

  localparam logic [LC_W-1:0]   LC_LUNG_LO = LC_W'(2 * WORD_COUNT);
  localparam logic [LC_W-1:0]   LC_LUNG_HI = LC_W'(2 * WORD_COUNT + 1);
  localparam logic [LC_W-1:0]   LC_FULL    = LC_W'(2 * WORD_COUNT + 2);
  localparam logic [POS_W-1:0]  POS_END    = POS_W'(2 * WORD_COUNT);
  localparam logic [ADDR_W-1:0] IDX_LAST   = ADDR_W'(WORD_COUNT - 1);
  localparam logic [BPTR_W-1:0] B_LAST     = BPTR_W'(WORD_COUNT - 1);
  localparam logic [BPTR_W:0]   B_WRAP     = (BPTR_W + 1)'(WORD_COUNT);

  // configuration
  logic [OFF_W-1:0]   pick_offset_q;
  logic [SHIFT_W-1:0] left_shift_q;
  lane_t              mask_low_q, mask_high_q;

  // state
  lane_t              lung_lo_q, lung_lo_d, lung_hi_q, lung_hi_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LC_W-1:0]    load_cnt_q, load_cnt_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [BPTR_W-1:0]  bptr_q, bptr_d;
  logic               zero_q, zero_d, zero_now;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q;

  // memory ports
  logic               lo_we, hi_we, load_word;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  lane_t              lo_wdata, hi_wdata;
  lane_t              lo_a, hi_a, lo_b, hi_b;

  // recursion
  lane_t              n0, n1, new_lo, new_hi, lane_sel;
  logic [BPTR_W:0]    bptr_sub;

  assign load_word = cmd_i.load && (load_cnt_q < LC_LUNG_LO);
  assign waddr     = cmd_i.gen_wr ? idx_q : ADDR_W'(load_cnt_q >> 1);
  assign raddr_a   = cmd_i.rd_lane ? ADDR_W'(pos_q >> 1) : idx_q;
  assign raddr_b   = bptr_q[ADDR_W-1:0];

  assign lo_we    = cmd_i.gen_wr || (load_word && !load_cnt_q[0]);
  assign hi_we    = cmd_i.gen_wr || (load_word && load_cnt_q[0]);
  assign lo_wdata = cmd_i.gen_wr ? new_lo : seed_word_i;
  assign hi_wdata = cmd_i.gen_wr ? new_hi : seed_word_i;

  dsfmt_lg_ram #(.WIDTH(LANE_W), .DEPTH(WORD_COUNT)) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (lo_we),
    .waddr_i   (waddr),
    .wdata_i   (lo_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (lo_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (lo_b)
  );

  dsfmt_lg_ram #(.WIDTH(LANE_W), .DEPTH(WORD_COUNT)) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (hi_we),
    .waddr_i   (waddr),
    .wdata_i   (hi_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (hi_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (hi_b)
  );

  // cross-coupled lung: the new low lane is computed from the old high lane, half-swapped
  always_comb begin
    n0 = (lo_a << left_shift_q) ^ (lung_hi_q >> LUNG_ROT) ^ (lung_hi_q << LUNG_ROT) ^ lo_b;
    n1 = (hi_a << left_shift_q) ^ (lung_lo_q >> LUNG_ROT) ^ (lung_lo_q << LUNG_ROT) ^ hi_b;
    new_lo = (n0 >> SHIFT_RIGHT) ^ (n0 & mask_low_q) ^ lo_a;
    new_hi = (n1 >> SHIFT_RIGHT) ^ (n1 & mask_high_q) ^ hi_a;
  end

  assign zero_now = zero_q && !(cmd_i.scan_chk && ((lo_a | hi_a) != '0));
  assign bptr_sub = {1'b0, bptr_q} - B_WRAP;
  assign lane_sel = pos_q[0] ? hi_a : lo_a;

  always_comb begin
    lung_lo_d   = lung_lo_q;
    lung_hi_d   = lung_hi_q;
    pos_d       = pos_q;
    load_cnt_d  = load_cnt_q;
    idx_d       = idx_q;
    bptr_d      = bptr_q;
    zero_d      = zero_now;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      if (load_cnt_q == LC_LUNG_LO) begin
        lung_lo_d = seed_word_i;
      end
      if (load_cnt_q == LC_LUNG_HI) begin
        lung_hi_d = seed_word_i;
      end
      if (load_cnt_q < LC_FULL) begin
        load_cnt_d = load_cnt_q + 1'b1;
      end
    end
    if (cmd_i.start) begin
      load_cnt_d = '0;
      pos_d      = '0;
      idx_d      = '0;
      zero_d     = ((lung_lo_q | lung_hi_q) == '0);
    end
    if (cmd_i.pos_clear) begin
      pos_d = '0;
    end
    if (cmd_i.idx_step) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.guard && zero_now) begin
      lung_lo_d = LANE_W'(1);
    end
    if (cmd_i.off_load) begin
      bptr_d = BPTR_W'(pick_offset_q);
      idx_d  = '0;
    end
    if (cmd_i.off_sub) begin
      bptr_d = bptr_sub[BPTR_W-1:0];
    end
    if (cmd_i.gen_wr) begin
      lung_lo_d = n0;
      lung_hi_d = n1;
      idx_d     = idx_q + 1'b1;
      bptr_d    = (bptr_q == B_LAST) ? '0 : bptr_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      pos_d       = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_offset_q <= OFF_W'(1);
      left_shift_q  <= SHIFT_W'(19);
      mask_low_q    <= '0;
      mask_high_q   <= '0;
      lung_lo_q     <= '0;
      lung_hi_q     <= '0;
      pos_q         <= '0;
      load_cnt_q    <= '0;
      idx_q         <= '0;
      bptr_q        <= '0;
      zero_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PICK_OFFSET: pick_offset_q <= cfg_wdata_i[OFF_W-1:0];
          CFG_LEFT_SHIFT:  left_shift_q  <= cfg_wdata_i[SHIFT_W-1:0];
          CFG_MASK_LOW:    mask_low_q    <= cfg_wdata_i;
          CFG_MASK_HIGH:   mask_high_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      lung_lo_q   <= lung_lo_d;
      lung_hi_q   <= lung_hi_d;
      pos_q       <= pos_d;
      load_cnt_q  <= load_cnt_d;
      idx_q       <= idx_d;
      bptr_q      <= bptr_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= lane_sel[VALUE_W-1:0];
    end
  end

  assign status_o.idx_last = (idx_q == IDX_LAST);
  assign status_o.off_ge   = ({1'b0, bptr_q} >= B_WRAP);
  assign status_o.pos_end  = (pos_q >= POS_END);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

endmodule

// ===== design/dsfmt_linear_generator_top.sv =====
// Linear generator of the double-precision SIMD twister family: WORD_COUNT
// 128-bit state words (two 64-bit lanes each, held in a pair of dual-read
// RAMs) plus a 128-bit lung. A load request (op 0) writes the next 64-bit seed
// lane; lanes past the words go to the lung, and loads beyond that are
// dropped. A start request (op 1) scans the store for an all-zero state,
// reduces pick_offset modulo the word count (with one subtract when the
// offset is not below the word count), regenerates every word in place
// (registered RAM read, then compute and write back), and returns word 0's
// low lane. A draw request (op 2) returns the next lane masked to 52 bits.
// Every 2*WORD_COUNT draws one draw first pays a full regeneration pass.
// Input requests are stalled while a start or draw is in progress; the
// result sits in an output register and is held while out_stall_i is high.
// Configuration registers must only be written while no start or draw is in
// progress.
module dsfmt_linear_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsfmt_lg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dsfmt_lg_pkg::LANE_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dsfmt_lg_pkg::op_t                   op_i,
  input  logic [dsfmt_lg_pkg::LANE_W-1:0]     seed_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dsfmt_lg_pkg::VALUE_W-1:0]    random_value_o
);

  import dsfmt_lg_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    start_req;

  // FSM: sequences scan, offset reduction, regeneration and emit
  dsfmt_lg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // state RAMs, lung, counters, recursion and output register
  dsfmt_lg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_word_i    (seed_word_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  // start request taken at this edge
  assign start_req = in_valid_i && !in_stall_o && (op_i == OP_START);

`include "dsfmt_linear_generator_top_assert.svh"

  // the output register is only loaded when its previous result has gone
  `DSFMT_ASSERT_NOW(a_emit_slot_free, cmd.emit, status.out_free, "emit into occupied output")

  // an accepted start request locks out the input for the regeneration
  `DSFMT_ASSERT_NEXT(a_start_locks, start_req, in_stall_o, "input open after start")

  // a result appears only as the product of an emit
  `DSFMT_ASSERT_NOW(a_valid_from_emit, $rose(out_valid_o), $past(cmd.emit), "result without emit")

  // seed writes and write-back never share the RAM write port
  `DSFMT_ASSERT_NOW(a_one_writer, cmd.gen_wr, !cmd.load, "load during regeneration")

endmodule

// ===== tb/dsfmt_linear_generator_checker.sv =====
// Watches both channels and the register port, keeps its own copy of the
// generator state and compares every result with the oldest prediction.
module dsfmt_linear_generator_checker
  import dsfmt_lg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  lane_t                cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  op_t                  op_i,
  input  lane_t                seed_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [VALUE_W-1:0]   random_value_i,
  output int                   pending_o,
  output int                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES = 2 * WORD_COUNT;
  localparam int SPLIT = 12;  // right shift of the new lung lanes
  localparam int ROT   = 32;  // half-lane swap of the old lung

  lane_t              word_lo [WORD_COUNT];
  lane_t              word_hi [WORD_COUNT];
  lane_t              lung_lo, lung_hi;
  int unsigned        next_lane, seeded;
  logic [OFF_W-1:0]   pick;
  logic [SHIFT_W-1:0] shl;
  lane_t              keep_lo, keep_hi;
  logic [VALUE_W-1:0] value_q [$];
  int                 fails = 0;

  assign fail_count_o = fails;

  // One in-place pass over every word; words below i are already new.
  function automatic void regenerate_words();
    int unsigned b;
    lane_t a0, a1, n0, n1;
    for (int unsigned i = 0; i < WORD_COUNT; i++) begin
      b  = (i + pick) % WORD_COUNT;
      a0 = word_lo[i];
      a1 = word_hi[i];
      n0 = (a0 << shl) ^ (lung_hi >> ROT) ^ (lung_hi << ROT) ^ word_lo[b];
      n1 = (a1 << shl) ^ (lung_lo >> ROT) ^ (lung_lo << ROT) ^ word_hi[b];
      word_lo[i] = (n0 >> SPLIT) ^ (n0 & keep_lo) ^ a0;
      word_hi[i] = (n1 >> SPLIT) ^ (n1 & keep_hi) ^ a1;
      lung_lo = n0;
      lung_hi = n1;
    end
  endfunction

  always @(posedge clk_i) begin : predict
    bit                 nonzero;
    lane_t              picked;
    logic [VALUE_W-1:0] want;
    if (!rst_ni) begin
      pick      = 8'd1;
      shl       = 6'd19;
      keep_lo   = '0;
      keep_hi   = '0;
      lung_lo   = '0;
      lung_hi   = '0;
      next_lane = 0;
      seeded    = 0;
      value_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PICK_OFFSET: pick    = cfg_wdata_i[OFF_W-1:0];
          CFG_LEFT_SHIFT:  shl     = cfg_wdata_i[SHIFT_W-1:0];
          CFG_MASK_LOW:    keep_lo = cfg_wdata_i;
          CFG_MASK_HIGH:   keep_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_LOAD: begin
            if (seeded < LANES) begin
              if (seeded % 2) word_hi[seeded / 2] = seed_word_i;
              else word_lo[seeded / 2] = seed_word_i;
            end else if (seeded == LANES) begin
              lung_lo = seed_word_i;
            end else if (seeded == LANES + 1) begin
              lung_hi = seed_word_i;
            end
            if (seeded < LANES + 2) seeded++;
          end
          OP_START: begin
            nonzero = (lung_lo | lung_hi) != '0;
            for (int i = 0; i < WORD_COUNT; i++)
              if ((word_lo[i] | word_hi[i]) != '0) nonzero = 1'b1;
            if (!nonzero) lung_lo = 64'd1;
            regenerate_words();
            value_q.push_back(word_lo[0][VALUE_W-1:0]);
            next_lane = 1;
            seeded    = 0;
          end
          OP_DRAW: begin
            if (next_lane >= LANES) begin
              regenerate_words();
              next_lane = 0;
            end
            picked = (next_lane % 2) ? word_hi[next_lane / 2] : word_lo[next_lane / 2];
            value_q.push_back(picked[VALUE_W-1:0]);
            next_lane++;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (value_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result, random_value %h", $time, random_value_i);
          fails++;
        end else begin
          want = value_q.pop_front();
          if (want !== random_value_i) begin
            if (fails < 10)
              $display("%0t: random_value expected %h, got %h", $time, want,
                       random_value_i);
            fails++;
          end
        end
      end
    end
    pending_o <= value_q.size();
  end

endmodule

// ===== tb/dsfmt_linear_generator_top_tb.sv =====
module dsfmt_linear_generator_top_tb;
  import dsfmt_lg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam op_t OP_UNUSED  = 2'd3;     // no-op request, gives no result
  localparam int  LANES      = 2 * WORD_COUNT;
  localparam int  LONG_HOLD  = 250;      // receiver hold-off, long enough to back up the input
  localparam int  SETTLE     = 16;       // a load gives no result; let it finish before config
  localparam int  TAIL       = 64;       // quiet cycles after the last result
  localparam int  IDLE_LIMIT = 10000;    // idle cycles before the watchdog fires

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  lane_t                cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  op_t                  op_i        = OP_LOAD;
  lane_t                seed_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [VALUE_W-1:0]   random_value_o;

  int          pending;
  int          fail_count;
  int unsigned holds_asked = 0;   // bumped by the sender
  int unsigned holds_done  = 0;   // bumped by the receiver
  int unsigned sent        = 0;
  int unsigned stuck       = 0;
  bit          offering    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dsfmt_linear_generator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .seed_word_i    (seed_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  dsfmt_linear_generator_checker value_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .seed_word_i    (seed_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_i (random_value_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // Lane values: mostly random, with all-zero and all-one lanes mixed in.
  function automatic lane_t any_lane();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one request and wait for it to be taken. Every fourth stretch of
  // 20 requests goes back to back; otherwise a random gap comes first.
  task automatic offer(op_t op, lane_t seed);
    int unsigned gap;
    gap = ((sent / 20) % 4 == 2) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    seed_word_i <= seed;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // Stop offering and wait until every predicted result has come back, then
  // give a trailing load time to land before anything touches the registers.
  task automatic drain();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, lane_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [OFF_W-1:0] off, logic [SHIFT_W-1:0] sh,
                            lane_t keep_lo, lane_t keep_hi);
    put_reg(CFG_PICK_OFFSET, lane_t'(off));
    put_reg(CFG_LEFT_SHIFT, lane_t'(sh));
    put_reg(CFG_MASK_LOW, keep_lo);
    put_reg(CFG_MASK_HIGH, keep_hi);
    cfg_we_i <= 1'b0;
  endtask

  // Load a run of seed lanes from the current load position.
  task automatic seed_state(int unsigned lanes, bit zeros);
    for (int unsigned k = 0; k < lanes; k++)
      offer(OP_LOAD, zeros ? lane_t'(0) : any_lane());
  endtask

  // Random request mix. A reseed is a well-formed burst: a short run of loads
  // followed by a start. A quarter of the way in the receiver is asked for a
  // long hold-off; halfway the sender waits for every result to come back.
  task automatic random_mix(int unsigned count, int unsigned reseed_pct,
                            int unsigned start_pct, int unsigned load_pct);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < reseed_pct) begin
        seed_state($urandom_range(1, 12), 1'b0);
        offer(OP_START, any_lane());
      end else if (r < reseed_pct + start_pct) begin
        offer(OP_START, any_lane());
      end else if (r < reseed_pct + start_pct + load_pct) begin
        offer(OP_LOAD, any_lane());
      end else if (r < reseed_pct + start_pct + load_pct + 3) begin
        offer(OP_UNUSED, any_lane());
      end else begin
        offer(OP_DRAW, any_lane());
      end
      if (n == count / 4) holds_asked++;
      if (n == count / 2) drain();
    end
  endtask

  // Receiver: a random stall before each result, with every third stretch of
  // 24 results taken without stalling, plus the long hold-off on request.
  initial begin : sink
    int unsigned pause;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      pause = ((taken / 24) % 3 == 1) ? 0 : $urandom_range(0, 19);
      if (holds_done < holds_asked) begin
        pause += LONG_HOLD;
        holds_done++;
      end
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  // Watchdog: too long without any request, result or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck <= 0;
    end else if (stuck == IDLE_LIMIT) begin
      $display("[dsfmt_linear_generator_top] ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values. The whole store and the lung are seeded with
    // zeros before the first start or draw, so nothing unwritten is ever
    // read, and the first start trips the zero guard.
    seed_state(LANES + 2, 1'b1);
    // Past the lung: these loads are dropped and the count saturates.
    offer(OP_LOAD, '1);
    offer(OP_LOAD, any_lane());
    // Draws before any start read the seeded store directly.
    repeat (3) offer(OP_DRAW, any_lane());
    offer(OP_UNUSED, '1);
    offer(OP_START, '0);
    repeat (4) offer(OP_DRAW, '1);
    // Partial reseed, lanes 0 and 1 get the extremes: untouched words keep
    // their regenerated contents.
    offer(OP_LOAD, '1);
    offer(OP_LOAD, '0);
    seed_state(6, 1'b0);
    offer(OP_START, any_lane());
    repeat (2) offer(OP_DRAW, any_lane());

    // Low extremes of offset and shift, masks fully open.
    drain();
    set_config(8'd0, 6'd0, '1, '1);
    offer(OP_START, any_lane());
    repeat (3) offer(OP_DRAW, any_lane());

    // High extremes with a short random reseed.
    drain();
    set_config(8'(WORD_COUNT - 1), 6'd63, any_lane(), any_lane());
    seed_state(8, 1'b0);
    offer(OP_START, any_lane());
    repeat (3) offer(OP_DRAW, any_lane());

    // Long draw stream with no starts, so the read position wraps and a draw
    // pays for a full regeneration.
    drain();
    set_config(8'($urandom_range(0, WORD_COUNT - 1)), 6'($urandom_range(0, 63)),
               any_lane(), any_lane());
    random_mix(420, 0, 0, 2);

    // Mixed traffic with starts and short reseed bursts.
    drain();
    set_config(8'($urandom_range(0, WORD_COUNT - 1)), 6'($urandom_range(0, 63)),
               any_lane(), any_lane());
    random_mix(60, 4, 6, 20);

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[dsfmt_linear_generator_top] OK");
    end else begin
      $display("[dsfmt_linear_generator_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== dsfmt_linear_generator_top.f =====
+incdir+design
design/dsfmt_lg_pkg.sv
design/dsfmt_lg_ram.sv
design/dsfmt_lg_ctrl.sv
design/dsfmt_lg_datapath.sv
design/dsfmt_linear_generator_top.sv
tb/dsfmt_linear_generator_checker.sv
tb/dsfmt_linear_generator_top_tb.sv
